// ===== hdl/esc_pkg.sv =====
`default_nettype none

package esc_pkg;

  localparam int FRAC_BITS_DEFAULT = 32;

  localparam int CMD_W      = 2;
  localparam int RAW_W      = 20;
  localparam int VALUE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int SH_W       = 7;
  localparam int DST_W      = 3;

  localparam logic [CMD_W-1:0] CMD_TEMP  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PRESS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HUM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_B   = 3'd5;

  localparam logic [DST_W-1:0] R0 = 3'd0;
  localparam logic [DST_W-1:0] R1 = 3'd1;
  localparam logic [DST_W-1:0] R2 = 3'd2;
  localparam logic [DST_W-1:0] R3 = 3'd3;
  localparam logic [DST_W-1:0] R4 = 3'd4;

  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_FIN, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_SHR, OP_MUL, OP_DIV, OP_CLAMP, OP_BRZ, OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4,
    SRC_RAWQ, SRC_T1Q, SRC_T2, SRC_T3, SRC_FIVE,
    SRC_FTQ, SRC_K64000Q, SRC_P1, SRC_P2, SRC_P3, SRC_P4Q, SRC_P5X2, SRC_P6,
    SRC_P7Q, SRC_P8, SRC_P9, SRC_RAWPQ, SRC_K6250, SRC_ONE,
    SRC_VHQ, SRC_H1, SRC_H2, SRC_H3, SRC_H4Q, SRC_H5, SRC_H6, SRC_ZERO
  } src_t;

  typedef struct packed {
    op_t              op;
    src_t             a;
    src_t             b;
    logic [SH_W-1:0]  sh;
    logic [DST_W-1:0] dst;
  } uop_t;

  function automatic uop_t mk_uop(op_t op, src_t a, src_t b, logic [SH_W-1:0] sh,
                                  logic [DST_W-1:0] dst);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.sh  = sh;
    u.dst = dst;
    return u;
  endfunction

  function automatic logic signed [63:0] sx16(logic [15:0] f);
    return $signed({{48{f[15]}}, f});
  endfunction

  function automatic logic signed [63:0] sx8(logic [7:0] f);
    return $signed({{56{f[7]}}, f});
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return $signed(s[63:0]);
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return $signed(s[63:0]);
  endfunction

  // Integer to fixed point, saturated.
  function automatic logic signed [63:0] from_int(logic signed [63:0] x, int frac);
    logic signed [63:0] lim;
    lim = Q_MAX >>> frac;
    if (x > lim) return Q_MAX;
    if (x < -lim - 64'sd1) return Q_MIN;
    return x <<< frac;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Signed result from a magnitude; round toward minus infinity when bits were dropped.
  function automatic logic signed [63:0] from_mag(logic neg, logic [127:0] q, logic dropped);
    logic [127:0] qq;
    qq = q + 128'(neg && dropped);
    if (!neg) return (qq > 128'(Q_MAX)) ? Q_MAX : $signed(qq[63:0]);
    if (qq >= 128'h8000_0000_0000_0000) return Q_MIN;
    return -$signed(qq[63:0]);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Truncate toward zero to an integer, then saturate.
  function automatic logic signed [31:0] trunc_int(logic signed [63:0] v, int frac);
    logic [63:0] m;
    logic signed [63:0] w;
    m = mag(v) >> frac;
    w = v[63] ? -$signed(m) : $signed(m);
    return sat32(w);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/env_sensor_compensation.sv =====
// Environmental sensor compensation: temperature, pressure and humidity.
//
// Input stream (s_axis_*): one item per raw sample. tuser carries the command
// (0 temperature, 1 pressure, 2 humidity), tdata the 20-bit raw sample.
// Output stream (m_axis_*): exactly one item per input item. tdata is the
// signed 32-bit value (centi-degC, 1/256 Pa or 1/1024 %RH), tuser holds the
// echoed kind and the zero-divisor flag.
// Config channel (cfg_*): writes one calibration register by index; issue
// writes only while the block is idle. cfg_ready is always high.
//
// Each item runs as a short micro-program on one shared unit: add/sub/shift/clamp
// steps, a 64x64 multiply built from four 32x32 partial products, and a
// bit-serial divider. The result is then loaded into the output register.
// One item is in flight at a time; s_axis_tready is high only while the
// sequencer is idle.
// A finished result sits in the output register while the next item is
// accepted; if the receiver stalls with a result still held, the sequencer
// holds its own result until the register frees up.
// Reset clears the calibration registers, the fine temperature and the
// sequencer state; the output goes invalid.
`default_nettype none

module env_sensor_compensation #(
  parameter int INTERNAL_FRACTION_BITS = esc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // [19:0] raw_sample
  input  logic [esc_pkg::CMD_W-1:0]        s_axis_tuser,  // [1:0] command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [esc_pkg::VALUE_W-1:0]      m_axis_tdata,  // [31:0] value
  output logic [2:0]                       m_axis_tuser   // [1:0] kind, [2] zero_divisor
);

  localparam int F = INTERNAL_FRACTION_BITS;
  localparam logic signed [63:0] ONE_Q     = 64'sd1 <<< F;
  localparam logic signed [63:0] HUNDRED_Q = 64'sd100 <<< F;
  localparam logic [6:0] SH_F    = 7'(F);
  localparam logic [6:0] SH_F8   = 7'(F + 8);
  localparam logic [6:0] SH_F15  = 7'(F + 15);
  localparam logic [6:0] SH_F19  = 7'(F + 19);
  localparam logic [6:0] SH_F31  = 7'(F + 31);
  localparam logic [6:0] SH_FM8  = 7'(F - 8);
  localparam logic [6:0] SH_FM10 = 7'(F - 10);

  // Calibration registers
  logic [47:0] temp_c, press_a, press_b, press_c;
  logic [31:0] hum_a;
  logic [39:0] hum_b;
  logic signed [31:0] fine_t;

  // Item and sequencer state
  esc_pkg::state_t state, state_next;
  logic [esc_pkg::CMD_W-1:0] cmd;
  logic [esc_pkg::RAW_W-1:0] raw;
  logic [4:0] step;
  logic signed [63:0] r0, r1, r2, r3, r4;

  // Shared multiply/divide unit
  logic [127:0] acc;
  logic [63:0]  pp, ua, ub, rem;
  logic [1:0]   pp_off;
  logic [6:0]   cnt, sh;
  logic [2:0]   dst;
  logic         neg;

  logic signed [31:0] res_value;
  logic               res_zero;

  esc_pkg::uop_t uop;
  logic signed [63:0] a_val, b_val, alu_res, fin_res, wr_val;
  logic [2:0]  wr_dst;
  logic        wr_en, load_out, a_zero;
  logic [64:0] remt;
  logic        ge;

  assign cfg_ready = 1'b1;

  // Item-derived immediates
  logic signed [63:0] raw_q, t1_q, ft_q, k64000_q, p4_q, p7_q, rawp_q, vh_q, h4_q;
  logic signed [63:0] ft_x;
  assign ft_x     = $signed({{32{fine_t[31]}}, fine_t});
  assign raw_q    = esc_pkg::from_int($signed({44'b0, raw}), F);
  assign t1_q     = esc_pkg::from_int($signed({48'b0, temp_c[15:0]}), F);
  assign ft_q     = esc_pkg::from_int(ft_x, F);
  assign k64000_q = esc_pkg::from_int(64'sd64000, F);
  assign p4_q     = esc_pkg::from_int(esc_pkg::sx16(press_b[15:0]) <<< 16, F);
  assign p7_q     = esc_pkg::from_int(esc_pkg::sx16(press_c[15:0]), F);
  assign rawp_q   = esc_pkg::from_int(64'sd1048576 - $signed({44'b0, raw}), F);
  assign vh_q     = esc_pkg::from_int(ft_x - 64'sd76800, F);
  assign h4_q     = esc_pkg::from_int(esc_pkg::sx16(hum_b[15:0]) <<< 6, F);

  function automatic logic signed [63:0] pick(esc_pkg::src_t s);
    logic signed [63:0] v;
    case (s)
      esc_pkg::SRC_R0:      v = r0;
      esc_pkg::SRC_R1:      v = r1;
      esc_pkg::SRC_R2:      v = r2;
      esc_pkg::SRC_R3:      v = r3;
      esc_pkg::SRC_R4:      v = r4;
      esc_pkg::SRC_RAWQ:    v = raw_q;
      esc_pkg::SRC_T1Q:     v = t1_q;
      esc_pkg::SRC_T2:      v = esc_pkg::sx16(temp_c[31:16]);
      esc_pkg::SRC_T3:      v = esc_pkg::sx16(temp_c[47:32]);
      esc_pkg::SRC_FIVE:    v = 64'sd5;
      esc_pkg::SRC_FTQ:     v = ft_q;
      esc_pkg::SRC_K64000Q: v = k64000_q;
      esc_pkg::SRC_P1:      v = $signed({48'b0, press_a[15:0]});
      esc_pkg::SRC_P2:      v = esc_pkg::sx16(press_a[31:16]);
      esc_pkg::SRC_P3:      v = esc_pkg::sx16(press_a[47:32]);
      esc_pkg::SRC_P4Q:     v = p4_q;
      esc_pkg::SRC_P5X2:    v = esc_pkg::sx16(press_b[31:16]) <<< 1;
      esc_pkg::SRC_P6:      v = esc_pkg::sx16(press_b[47:32]);
      esc_pkg::SRC_P7Q:     v = p7_q;
      esc_pkg::SRC_P8:      v = esc_pkg::sx16(press_c[31:16]);
      esc_pkg::SRC_P9:      v = esc_pkg::sx16(press_c[47:32]);
      esc_pkg::SRC_RAWPQ:   v = rawp_q;
      esc_pkg::SRC_K6250:   v = 64'sd6250;
      esc_pkg::SRC_ONE:     v = ONE_Q;
      esc_pkg::SRC_VHQ:     v = vh_q;
      esc_pkg::SRC_H1:      v = $signed({56'b0, hum_a[7:0]});
      esc_pkg::SRC_H2:      v = esc_pkg::sx16(hum_a[23:8]);
      esc_pkg::SRC_H3:      v = $signed({56'b0, hum_a[31:24]});
      esc_pkg::SRC_H4Q:     v = h4_q;
      esc_pkg::SRC_H5:      v = esc_pkg::sx16(hum_b[31:16]);
      esc_pkg::SRC_H6:      v = esc_pkg::sx8(hum_b[39:32]);
      default:              v = 64'sd0;
    endcase
    return v;
  endfunction

  // Micro-programs, one step per entry
  always_comb begin
    uop = esc_pkg::mk_uop(esc_pkg::OP_OUT, esc_pkg::SRC_ZERO, esc_pkg::SRC_ZERO, 7'd0,
                          esc_pkg::R0);
    case (cmd)
      esc_pkg::CMD_TEMP: begin
        case (step)
          5'd0:  uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_RAWQ, esc_pkg::SRC_ZERO,
                                       7'd14, esc_pkg::R0);
          5'd1:  uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_T1Q, esc_pkg::SRC_ZERO,
                                       7'd10, esc_pkg::R1);
          5'd2:  uop = esc_pkg::mk_uop(esc_pkg::OP_SUB, esc_pkg::SRC_R0, esc_pkg::SRC_R1,
                                       7'd0, esc_pkg::R0);
          5'd3:  uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_RAWQ, esc_pkg::SRC_ZERO,
                                       7'd17, esc_pkg::R1);
          5'd4:  uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_T1Q, esc_pkg::SRC_ZERO,
                                       7'd13, esc_pkg::R2);
          5'd5:  uop = esc_pkg::mk_uop(esc_pkg::OP_SUB, esc_pkg::SRC_R1, esc_pkg::SRC_R2,
                                       7'd0, esc_pkg::R1);
          5'd6:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_T2,
                                       7'd0, esc_pkg::R0);
          5'd7:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R1, esc_pkg::SRC_R1,
                                       SH_F, esc_pkg::R1);
          5'd8:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R1, esc_pkg::SRC_T3,
                                       7'd0, esc_pkg::R1);
          5'd9:  uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_R0, esc_pkg::SRC_R1,
                                       7'd0, esc_pkg::R0);
          5'd10: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_FIVE,
                                       SH_F8, esc_pkg::R1);
          5'd11: uop = esc_pkg::mk_uop(esc_pkg::OP_OUT, esc_pkg::SRC_R1, esc_pkg::SRC_ZERO,
                                       7'd0, esc_pkg::R0);
          default: ;
        endcase
      end
      esc_pkg::CMD_PRESS: begin
        case (step)
          5'd0:  uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_FTQ, esc_pkg::SRC_ZERO,
                                       7'd1, esc_pkg::R0);
          5'd1:  uop = esc_pkg::mk_uop(esc_pkg::OP_SUB, esc_pkg::SRC_R0, esc_pkg::SRC_K64000Q,
                                       7'd0, esc_pkg::R0);
          5'd2:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_P6,
                                       7'd0, esc_pkg::R1);
          5'd3:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_R1,
                                       SH_F15, esc_pkg::R1);
          5'd4:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_P5X2,
                                       7'd0, esc_pkg::R2);
          5'd5:  uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_R1, esc_pkg::SRC_R2,
                                       7'd0, esc_pkg::R1);
          5'd6:  uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_R1, esc_pkg::SRC_ZERO,
                                       7'd2, esc_pkg::R1);
          5'd7:  uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_R1, esc_pkg::SRC_P4Q,
                                       7'd0, esc_pkg::R1);
          5'd8:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_P3,
                                       7'd0, esc_pkg::R2);
          5'd9:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_R2,
                                       SH_F19, esc_pkg::R2);
          5'd10: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_P2,
                                       7'd0, esc_pkg::R3);
          5'd11: uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_R2, esc_pkg::SRC_R3,
                                       7'd0, esc_pkg::R2);
          5'd12: uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_R2, esc_pkg::SRC_ZERO,
                                       7'd19, esc_pkg::R2);
          5'd13: uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_R2, esc_pkg::SRC_ZERO,
                                       7'd15, esc_pkg::R2);
          5'd14: uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_ONE, esc_pkg::SRC_R2,
                                       7'd0, esc_pkg::R2);
          5'd15: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R2, esc_pkg::SRC_P1,
                                       7'd0, esc_pkg::R0);
          5'd16: uop = esc_pkg::mk_uop(esc_pkg::OP_BRZ, esc_pkg::SRC_R0, esc_pkg::SRC_ZERO,
                                       7'd0, esc_pkg::R0);
          5'd17: uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_R1, esc_pkg::SRC_ZERO,
                                       7'd12, esc_pkg::R1);
          5'd18: uop = esc_pkg::mk_uop(esc_pkg::OP_SUB, esc_pkg::SRC_RAWPQ, esc_pkg::SRC_R1,
                                       7'd0, esc_pkg::R2);
          5'd19: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R2, esc_pkg::SRC_K6250,
                                       7'd0, esc_pkg::R2);
          5'd20: uop = esc_pkg::mk_uop(esc_pkg::OP_DIV, esc_pkg::SRC_R2, esc_pkg::SRC_R0,
                                       7'd0, esc_pkg::R2);
          5'd21: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R2, esc_pkg::SRC_P9,
                                       7'd0, esc_pkg::R3);
          5'd22: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R3, esc_pkg::SRC_R2,
                                       SH_F31, esc_pkg::R3);
          5'd23: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R2, esc_pkg::SRC_P8,
                                       7'd15, esc_pkg::R4);
          5'd24: uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_R3, esc_pkg::SRC_R4,
                                       7'd0, esc_pkg::R3);
          5'd25: uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_R3, esc_pkg::SRC_P7Q,
                                       7'd0, esc_pkg::R3);
          5'd26: uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_R3, esc_pkg::SRC_ZERO,
                                       7'd4, esc_pkg::R3);
          5'd27: uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_R2, esc_pkg::SRC_R3,
                                       7'd0, esc_pkg::R2);
          5'd28: uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_R2, esc_pkg::SRC_ZERO,
                                       SH_FM8, esc_pkg::R2);
          5'd29: uop = esc_pkg::mk_uop(esc_pkg::OP_OUT, esc_pkg::SRC_R2, esc_pkg::SRC_ZERO,
                                       7'd0, esc_pkg::R0);
          default: ;
        endcase
      end
      esc_pkg::CMD_HUM: begin
        case (step)
          5'd0:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_VHQ, esc_pkg::SRC_H5,
                                       7'd14, esc_pkg::R0);
          5'd1:  uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_H4Q, esc_pkg::SRC_R0,
                                       7'd0, esc_pkg::R0);
          5'd2:  uop = esc_pkg::mk_uop(esc_pkg::OP_SUB, esc_pkg::SRC_RAWQ, esc_pkg::SRC_R0,
                                       7'd0, esc_pkg::R0);
          5'd3:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_VHQ, esc_pkg::SRC_H3,
                                       7'd26, esc_pkg::R1);
          5'd4:  uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_ONE, esc_pkg::SRC_R1,
                                       7'd0, esc_pkg::R1);
          5'd5:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_VHQ, esc_pkg::SRC_H6,
                                       7'd26, esc_pkg::R2);
          5'd6:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R2, esc_pkg::SRC_R1,
                                       SH_F, esc_pkg::R2);
          5'd7:  uop = esc_pkg::mk_uop(esc_pkg::OP_ADD, esc_pkg::SRC_ONE, esc_pkg::SRC_R2,
                                       7'd0, esc_pkg::R2);
          5'd8:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R2, esc_pkg::SRC_H2,
                                       7'd16, esc_pkg::R2);
          5'd9:  uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_R2,
                                       SH_F, esc_pkg::R0);
          5'd10: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_H1,
                                       7'd19, esc_pkg::R1);
          5'd11: uop = esc_pkg::mk_uop(esc_pkg::OP_SUB, esc_pkg::SRC_ONE, esc_pkg::SRC_R1,
                                       7'd0, esc_pkg::R1);
          5'd12: uop = esc_pkg::mk_uop(esc_pkg::OP_MUL, esc_pkg::SRC_R0, esc_pkg::SRC_R1,
                                       SH_F, esc_pkg::R0);
          5'd13: uop = esc_pkg::mk_uop(esc_pkg::OP_CLAMP, esc_pkg::SRC_R0, esc_pkg::SRC_ZERO,
                                       7'd0, esc_pkg::R0);
          5'd14: uop = esc_pkg::mk_uop(esc_pkg::OP_SHR, esc_pkg::SRC_R0, esc_pkg::SRC_ZERO,
                                       SH_FM10, esc_pkg::R0);
          5'd15: uop = esc_pkg::mk_uop(esc_pkg::OP_OUT, esc_pkg::SRC_R0, esc_pkg::SRC_ZERO,
                                       7'd0, esc_pkg::R0);
          default: ;
        endcase
      end
      default: ;  // unused command: report zero
    endcase
  end

  assign a_val  = pick(uop.a);
  assign b_val  = pick(uop.b);
  assign a_zero = (a_val == 64'sd0);

  // Combinational ALU ops
  always_comb begin
    case (uop.op)
      esc_pkg::OP_ADD:   alu_res = esc_pkg::sat_add(a_val, b_val);
      esc_pkg::OP_SUB:   alu_res = esc_pkg::sat_sub(a_val, b_val);
      esc_pkg::OP_SHR:   alu_res = a_val >>> uop.sh;
      esc_pkg::OP_CLAMP: alu_res = (a_val > HUNDRED_Q) ? HUNDRED_Q :
                                   (a_val[63] ? 64'sd0 : a_val);
      default:           alu_res = a_val;
    endcase
  end

  // Round and saturate the multiply or divide result
  assign fin_res = esc_pkg::from_mag(neg, acc >> sh,
                     ((acc & ((128'd1 << sh) - 128'd1)) != 128'd0) || (rem != 64'd0));

  assign remt = {rem, acc[127]};
  assign ge   = (remt >= {1'b0, ub});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      esc_pkg::ST_IDLE: if (s_axis_tvalid) state_next = esc_pkg::ST_EXEC;
      esc_pkg::ST_EXEC: begin
        case (uop.op)
          esc_pkg::OP_MUL: state_next = esc_pkg::ST_MUL;
          esc_pkg::OP_DIV: state_next = esc_pkg::ST_DIV;
          esc_pkg::OP_OUT: state_next = esc_pkg::ST_DONE;
          esc_pkg::OP_BRZ: if (a_zero) state_next = esc_pkg::ST_DONE;
          default: ;
        endcase
      end
      esc_pkg::ST_MUL: if (cnt == 7'd4) state_next = esc_pkg::ST_FIN;
      esc_pkg::ST_DIV: if (cnt == 7'd127) state_next = esc_pkg::ST_FIN;
      esc_pkg::ST_FIN: state_next = esc_pkg::ST_EXEC;
      esc_pkg::ST_DONE: if (load_out) state_next = esc_pkg::ST_IDLE;
      default: state_next = esc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    wr_en         = 1'b0;
    wr_val        = alu_res;
    wr_dst        = uop.dst;
    case (state)
      esc_pkg::ST_IDLE: s_axis_tready = 1'b1;
      esc_pkg::ST_EXEC: begin
        wr_en = (uop.op == esc_pkg::OP_ADD) || (uop.op == esc_pkg::OP_SUB) ||
                (uop.op == esc_pkg::OP_SHR) || (uop.op == esc_pkg::OP_CLAMP);
      end
      esc_pkg::ST_FIN: begin
        wr_en  = 1'b1;
        wr_val = fin_res;
        wr_dst = dst;
      end
      esc_pkg::ST_DONE: load_out = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= esc_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      temp_c        <= '0;
      press_a       <= '0;
      press_b       <= '0;
      press_c       <= '0;
      hum_a         <= '0;
      hum_b         <= '0;
      fine_t        <= '0;
    end else begin
      state <= state_next;
      if (load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          esc_pkg::REG_TEMP:    temp_c  <= cfg_data;
          esc_pkg::REG_PRESS_A: press_a <= cfg_data;
          esc_pkg::REG_PRESS_B: press_b <= cfg_data;
          esc_pkg::REG_PRESS_C: press_c <= cfg_data;
          esc_pkg::REG_HUM_A:   hum_a   <= cfg_data[31:0];
          esc_pkg::REG_HUM_B:   hum_b   <= cfg_data[39:0];
          default: ;  // drop writes beyond the register list
        endcase
      end
      // Temperature result also refreshes the fine temperature from the Q sum
      if (state == esc_pkg::ST_EXEC && uop.op == esc_pkg::OP_OUT && cmd == esc_pkg::CMD_TEMP)
        fine_t <= esc_pkg::trunc_int(r0, F);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd  <= s_axis_tuser;
      raw  <= s_axis_tdata[19:0];
      step <= 5'd0;
    end
    if (wr_en) begin
      case (wr_dst)
        esc_pkg::R0: r0 <= wr_val;
        esc_pkg::R1: r1 <= wr_val;
        esc_pkg::R2: r2 <= wr_val;
        esc_pkg::R3: r3 <= wr_val;
        default:     r4 <= wr_val;
      endcase
    end
    case (state)
      esc_pkg::ST_EXEC: begin
        ua  <= esc_pkg::mag(a_val);
        ub  <= esc_pkg::mag(b_val);
        neg <= a_val[63] ^ b_val[63];
        dst <= uop.dst;
        cnt <= 7'd0;
        rem <= 64'd0;
        if (uop.op == esc_pkg::OP_DIV) begin
          acc <= 128'(esc_pkg::mag(a_val)) << F;
          sh  <= 7'd0;
        end else begin
          acc <= 128'd0;
          sh  <= uop.sh;
        end
        if (uop.op == esc_pkg::OP_OUT) begin
          res_value <= esc_pkg::sat32(a_val);
          res_zero  <= 1'b0;
        end else if (uop.op == esc_pkg::OP_BRZ && a_zero) begin
          res_value <= 32'sd0;
          res_zero  <= 1'b1;
        end
        if (wr_en || (uop.op == esc_pkg::OP_BRZ && !a_zero)) step <= step + 5'd1;
      end
      esc_pkg::ST_MUL: begin
        // Register a partial product, then accumulate it in the next cycle
        if (cnt != 7'd4) begin
          pp     <= (cnt[1] ? ua[63:32] : ua[31:0]) * (cnt[0] ? ub[63:32] : ub[31:0]);
          pp_off <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (cnt != 7'd0) acc <= acc + (128'(pp) << {pp_off, 5'b0});
        cnt <= cnt + 7'd1;
      end
      esc_pkg::ST_DIV: begin
        // One restoring step: quotient bit shifts in as numerator bit shifts out
        rem <= ge ? 64'(remt - {1'b0, ub}) : remt[63:0];
        acc <= {acc[126:0], ge};
        cnt <= cnt + 7'd1;
      end
      esc_pkg::ST_FIN: step <= step + 5'd1;
      default: ;
    endcase
    if (load_out) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= {res_zero, cmd};
    end
  end

  a_mul_bound: assert property (@(posedge clk) disable iff (rst)
    state == esc_pkg::ST_MUL |-> cnt <= 7'd4)
    else $error("multiply sequencer overran its partial products");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == esc_pkg::ST_DIV |-> ub != 64'd0)
    else $error("divider started with a zero divisor");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_axis_tvalid && state == esc_pkg::ST_IDLE)
    else $error("result load did not present the item and release the sequencer");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tuser[1:0] == esc_pkg::CMD_PRESS && m_axis_tdata == 32'd0)
    else $error("zero-divisor flag on a non-pressure or nonzero result");

endmodule

`default_nettype wire
